>>> rtl/core/csvp_pkg.sv
// Shared types and constants for the CSV record parser.
package csvp_pkg;

    localparam int MAX_FIELDS_DEF = 64;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    localparam int IDX_W  = 6;
    localparam int ERR_W  = 3;
    localparam int KIND_W = 2;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_FIELD,
        MODE_QUOTED,
        MODE_QCLOSE,
        MODE_AFTER_CR,
        MODE_AFTER_LF
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA      = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_REC_END   = 2'd2,
        KIND_ERROR     = 2'd3
    } kind_t;

    localparam logic [ERR_W-1:0] ERR_COUNT      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_QUOTE  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_AFTER_QT   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_UNCLOSED   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_TOO_MANY   = 3'd4;

endpackage

>>> rtl/core/csv_record_parser.sv
// Top level of the streaming CSV record parser.
//
// Input channel s_axis: one word per character. tdata[7:0] is the byte,
// tuser marks end of input (the byte is then ignored). End of input closes
// any open record (record end, count mismatch or unclosed-quote error) and
// returns the parser to its reset state, ready for a new stream.
// Output channel m_axis: zero or one event word per input word. tuser holds
// the event kind (data byte, field end, record end, error); tdata holds
// data_byte, field_index and error_code. The first record fixes the field
// count; after the first error one error word is sent and further bytes are
// dropped silently until end of input.
// Path: an accepted word is held in the input register and is parsed by a
// single level of state logic into the result register, which drives m_axis.
// Throughput: one word per cycle while the receiver does not stall.
// A stalled receiver holds the result register; the input register takes a
// word while it is empty or its own word moves on into a free or draining
// result register, so at most two words are in flight. Reset clears all
// parser state and both valid flags; there is no clearing pass.
module csv_record_parser
    import csvp_pkg::*;
#(
    parameter int MAX_FIELDS = MAX_FIELDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic        s_axis_tuser,   // [0] end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [13:8] field_index,
                                        // [16:14] error_code, [23:17] zero
    output logic [1:0]  m_axis_tuser    // [1:0] kind
);

    // field counter covers 0..MAX_FIELDS-1, expected count 1..MAX_FIELDS
    localparam int FW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
    localparam int EW = $clog2(MAX_FIELDS + 1);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eoi_reg;

    // parser state
    mode_t          mode_reg, mode_next;
    logic           has_reg, has_next;
    logic [FW-1:0]  fld_reg, fld_next;
    logic [EW-1:0]  exp_reg, exp_next;
    logic           hdr_reg, hdr_next;
    logic           open_reg, open_next;
    logic           halt_reg, halt_next;

    // result register
    logic              out_valid_reg;
    kind_t             out_kind_reg;
    logic [7:0]        out_byte_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic [ERR_W-1:0]  out_err_reg;

    // event from the parse logic
    logic              ev_valid;
    kind_t             ev_kind;
    logic [7:0]        ev_byte;
    logic [FW-1:0]     ev_fld;
    logic [ERR_W-1:0]  ev_err;

    logic advance;

    // the held word is parsed when the result register can take its event
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eoi_reg  <= s_axis_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            has_reg  <= 1'b0;
            fld_reg  <= '0;
            exp_reg  <= '0;
            hdr_reg  <= 1'b0;
            open_reg <= 1'b0;
            halt_reg <= 1'b0;
        end
        else if (in_valid_reg && advance)
        begin
            mode_reg <= mode_next;
            has_reg  <= has_next;
            fld_reg  <= fld_next;
            exp_reg  <= exp_next;
            hdr_reg  <= hdr_next;
            open_reg <= open_next;
            halt_reg <= halt_next;
        end
    end

    // parse step: one character against the current state
    always_comb
    begin
        logic [7:0] b;
        mode_t      m;
        logic       skip;
        logic       is_delim;
        logic       do_fail;
        logic       do_end;
        logic [ERR_W-1:0] fcode;

        b        = in_byte_reg;
        m        = mode_reg;
        skip     = 1'b0;
        do_fail  = 1'b0;
        do_end   = 1'b0;
        fcode    = ERR_COUNT;
        is_delim = (b == CH_COMMA) || (b == CH_LF) || (b == CH_CR);

        mode_next = mode_reg;
        has_next  = has_reg;
        fld_next  = fld_reg;
        exp_next  = exp_reg;
        hdr_next  = hdr_reg;
        open_next = open_reg;
        halt_next = halt_reg;

        ev_valid = 1'b0;
        ev_kind  = KIND_DATA;
        ev_byte  = 8'd0;
        ev_fld   = fld_reg;
        ev_err   = ERR_COUNT;

        if (in_eoi_reg)
        begin
            if (!halt_reg && open_reg)
            begin
                ev_valid = 1'b1;
                if (mode_reg == MODE_QUOTED)
                begin
                    ev_kind = KIND_ERROR;
                    ev_err  = ERR_UNCLOSED;
                end
                else if (hdr_reg && ((EW'(fld_reg) + EW'(1)) != exp_reg))
                begin
                    ev_kind = KIND_ERROR;
                    ev_err  = ERR_COUNT;
                end
                else
                begin
                    ev_kind = KIND_REC_END;
                end
            end
            mode_next = MODE_IDLE;
            has_next  = 1'b0;
            fld_next  = '0;
            exp_next  = '0;
            hdr_next  = 1'b0;
            open_next = 1'b0;
            halt_next = 1'b0;
        end
        else if (!halt_reg)
        begin
            // second half of a two-character line end is swallowed
            if (m == MODE_AFTER_CR || m == MODE_AFTER_LF)
            begin
                if ((m == MODE_AFTER_CR && b == CH_LF) ||
                    (m == MODE_AFTER_LF && b == CH_CR))
                begin
                    skip = 1'b1;
                end
                m         = MODE_IDLE;
                mode_next = MODE_IDLE;
            end
            if (!skip)
            begin
                if (m == MODE_IDLE)
                begin
                    fld_next  = '0;
                    has_next  = 1'b0;
                    open_next = 1'b1;
                    m         = MODE_FIELD;
                    mode_next = MODE_FIELD;
                end
                ev_fld = fld_next;

                unique case (m)
                    MODE_QUOTED:
                    begin
                        if (b == CH_QUOTE)
                        begin
                            mode_next = MODE_QCLOSE;
                        end
                        else
                        begin
                            has_next = 1'b1;
                            ev_valid = 1'b1;
                            ev_kind  = KIND_DATA;
                            ev_byte  = b;
                        end
                    end
                    MODE_QCLOSE:
                    begin
                        if (b == CH_QUOTE)
                        begin
                            mode_next = MODE_QUOTED;
                            has_next  = 1'b1;
                            ev_valid  = 1'b1;
                            ev_kind   = KIND_DATA;
                            ev_byte   = b;
                        end
                        else if (!is_delim)
                        begin
                            do_fail = 1'b1;
                            fcode   = ERR_AFTER_QT;
                        end
                        else
                        begin
                            do_end = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (b == CH_QUOTE)
                        begin
                            if (has_next)
                            begin
                                do_fail = 1'b1;
                                fcode   = ERR_BAD_QUOTE;
                            end
                            else
                            begin
                                mode_next = MODE_QUOTED;
                            end
                        end
                        else if (!is_delim)
                        begin
                            has_next = 1'b1;
                            ev_valid = 1'b1;
                            ev_kind  = KIND_DATA;
                            ev_byte  = b;
                        end
                        else
                        begin
                            do_end = 1'b1;
                        end
                    end
                endcase

                if (do_end)
                begin
                    if (b == CH_COMMA)
                    begin
                        if (hdr_reg && ((EW'(ev_fld) + EW'(1)) >= exp_reg))
                        begin
                            do_fail = 1'b1;
                            fcode   = ERR_COUNT;
                        end
                        else if (!hdr_reg && (ev_fld == FW'(MAX_FIELDS - 1)))
                        begin
                            do_fail = 1'b1;
                            fcode   = ERR_TOO_MANY;
                        end
                        else
                        begin
                            fld_next  = ev_fld + FW'(1);
                            has_next  = 1'b0;
                            mode_next = MODE_FIELD;
                            ev_valid  = 1'b1;
                            ev_kind   = KIND_FIELD_END;
                        end
                    end
                    else
                    begin
                        mode_next = (b == CH_CR) ? MODE_AFTER_CR : MODE_AFTER_LF;
                        if (hdr_reg && ((EW'(ev_fld) + EW'(1)) != exp_reg))
                        begin
                            do_fail = 1'b1;
                            fcode   = ERR_COUNT;
                        end
                        else
                        begin
                            if (!hdr_reg)
                            begin
                                exp_next = EW'(ev_fld) + EW'(1);
                                hdr_next = 1'b1;
                            end
                            open_next = 1'b0;
                            ev_valid  = 1'b1;
                            ev_kind   = KIND_REC_END;
                        end
                    end
                end

                if (do_fail)
                begin
                    halt_next = 1'b1;
                    open_next = 1'b0;
                    ev_valid  = 1'b1;
                    ev_kind   = KIND_ERROR;
                    ev_byte   = 8'd0;
                    ev_err    = fcode;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg && ev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg && ev_valid)
        begin
            out_kind_reg <= ev_kind;
            out_byte_reg <= ev_byte;
            out_idx_reg  <= IDX_W'(ev_fld);
            out_err_reg  <= ev_err;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {7'd0, out_err_reg, out_idx_reg, out_byte_reg};

endmodule

>>> rtl/core/csvp_checker.sv
// Port-level checks for the CSV record parser, bound to the top level.
module csvp_checker
    import csvp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // stalled event word must hold
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("event word changed while stalled");

    // error code only on error words, and in range there
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tuser == KIND_ERROR) ? (m_axis_tdata[16:14] <= ERR_TOO_MANY)
                                         : (m_axis_tdata[16:14] == ERR_COUNT))
        else $error("bad error_code for event kind");

    // data byte only on data words
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != KIND_DATA) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("data_byte set on non-data event");

    // padding stays clear
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:17] == 7'd0))
        else $error("tdata padding not zero");

endmodule

bind csv_record_parser csvp_checker u_csvp_checker (.*);

>>> bench/tb_csv_record_parser.sv
// Self-checking testbench for csv_record_parser: directed and random CSV streams.
module tb_csv_record_parser;
    import csvp_pkg::*;

    localparam int MAX_FIELDS   = MAX_FIELDS_DEF;
    localparam int RANDOM_WORDS = 1200;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        logic [7:0] ch;
        logic       eoi;
    } char_word_t;

    typedef struct {
        kind_t            kind;
        logic [7:0]       data;
        logic [IDX_W-1:0] idx;
        logic [ERR_W-1:0] err;
    } parse_event_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    char_word_t   char_queue[$];
    parse_event_t expected_events[$];
    int unsigned  generated_words;
    int unsigned  total_words;
    int unsigned  accepted_words;
    int unsigned  fail_count;
    int unsigned  cycle_count;
    int unsigned  hold_left;
    bit           hold_done;

    // Predictor state: a copy of the parser's own registers
    mode_t       pmode;
    bit          has_content;
    int unsigned cur_field;
    int unsigned exp_fields;
    bit          header_seen;
    bit          rec_open;
    bit          halted;

    csv_record_parser #(.MAX_FIELDS(MAX_FIELDS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] byte_in
        .s_axis_tuser  (s_axis_tuser),   // [0] end_of_input
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] data_byte, [13:8] field_index,
                                         // [16:14] error_code
        .m_axis_tuser  (m_axis_tuser)    // [1:0] kind
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void emit(kind_t kind, logic [7:0] data, int unsigned idx,
                                 logic [ERR_W-1:0] err);
        parse_event_t ev;
        ev.kind = kind;
        ev.data = data;
        ev.idx  = idx[IDX_W-1:0];
        ev.err  = err;
        expected_events.insert(expected_events.size(), ev);
    endfunction

    function automatic void parser_clear();
        pmode       = MODE_IDLE;
        has_content = 1'b0;
        cur_field   = 0;
        exp_fields  = 0;
        header_seen = 1'b0;
        rec_open    = 1'b0;
        halted      = 1'b0;
    endfunction

    // First error stops the parse until end of input
    function automatic void flag_error(logic [ERR_W-1:0] code);
        halted   = 1'b1;
        rec_open = 1'b0;
        emit(KIND_ERROR, 8'h00, cur_field, code);
    endfunction

    function automatic void take_comma();
        int unsigned nxt;
        nxt = cur_field + 1;
        if (header_seen && nxt >= exp_fields)
            flag_error(ERR_COUNT);
        else if (!header_seen && nxt >= MAX_FIELDS)
            flag_error(ERR_TOO_MANY);
        else
        begin
            emit(KIND_FIELD_END, 8'h00, cur_field, 3'd0);
            cur_field   = nxt;
            has_content = 1'b0;
            pmode       = MODE_FIELD;
        end
    endfunction

    // The first record fixes the field count; later ones must match
    function automatic void close_record();
        if (header_seen && cur_field + 1 != exp_fields)
            flag_error(ERR_COUNT);
        else
        begin
            if (!header_seen)
            begin
                exp_fields  = cur_field + 1;
                header_seen = 1'b1;
            end
            rec_open = 1'b0;
            emit(KIND_REC_END, 8'h00, cur_field, 3'd0);
        end
    endfunction

    function automatic void parse_char(logic [7:0] b, logic eoi);
        logic [7:0] partner;
        bit         is_delim;
        if (eoi)
        begin
            if (!halted && rec_open)
            begin
                if (pmode == MODE_QUOTED)
                    flag_error(ERR_UNCLOSED);
                else
                    close_record();
            end
            parser_clear();
            return;
        end
        if (halted)
            return;
        // second half of a two-character line end is swallowed
        if (pmode == MODE_AFTER_CR || pmode == MODE_AFTER_LF)
        begin
            partner = (pmode == MODE_AFTER_CR) ? CH_LF : CH_CR;
            pmode   = MODE_IDLE;
            if (b == partner)
                return;
        end
        if (pmode == MODE_IDLE)
        begin
            cur_field   = 0;
            has_content = 1'b0;
            rec_open    = 1'b1;
            pmode       = MODE_FIELD;
        end
        is_delim = (b == CH_COMMA) || (b == CH_LF) || (b == CH_CR);
        case (pmode)
            MODE_QUOTED:
            begin
                if (b == CH_QUOTE)
                    pmode = MODE_QCLOSE;
                else
                begin
                    has_content = 1'b1;
                    emit(KIND_DATA, b, cur_field, 3'd0);
                end
                return;
            end
            MODE_QCLOSE:
            begin
                if (b == CH_QUOTE)
                begin
                    pmode       = MODE_QUOTED;
                    has_content = 1'b1;
                    emit(KIND_DATA, b, cur_field, 3'd0);
                    return;
                end
                if (!is_delim)
                begin
                    flag_error(ERR_AFTER_QT);
                    return;
                end
            end
            default:
            begin
                if (b == CH_QUOTE)
                begin
                    if (has_content)
                        flag_error(ERR_BAD_QUOTE);
                    else
                        pmode = MODE_QUOTED;
                    return;
                end
                if (!is_delim)
                begin
                    has_content = 1'b1;
                    emit(KIND_DATA, b, cur_field, 3'd0);
                    return;
                end
            end
        endcase
        if (b == CH_COMMA)
            take_comma();
        else
        begin
            pmode = (b == CH_CR) ? MODE_AFTER_CR : MODE_AFTER_LF;
            close_record();
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    function automatic void add_char(logic [7:0] b);
        char_word_t w;
        w.ch  = b;
        w.eoi = 1'b0;
        char_queue.insert(char_queue.size(), w);
        generated_words++;
    endfunction

    // byte lane is random under end of input, it must be ignored
    function automatic void add_eoi();
        char_word_t w;
        w.ch  = 8'($urandom_range(0, 255));
        w.eoi = 1'b1;
        char_queue.insert(char_queue.size(), w);
        generated_words++;
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_COMMA || c == CH_LF || c == CH_CR || c == CH_QUOTE);
        return c;
    endfunction

    function automatic logic [7:0] any_char();
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0:       c = CH_COMMA;
            1:       c = CH_LF;
            2:       c = CH_CR;
            3:       c = CH_QUOTE;
            default: c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    function automatic void add_line_end();
        case ($urandom_range(0, 3))
            0:
            begin
                add_char(CH_CR);
                add_char(CH_LF);
            end
            1:
            begin
                add_char(CH_LF);
                add_char(CH_CR);
            end
            2:       add_char(CH_CR);
            default: add_char(CH_LF);
        endcase
    endfunction

    function automatic void add_field();
        int unsigned roll;
        int unsigned n;
        logic [7:0]  c;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            return;                              // empty field
        else if (roll < 60)
        begin
            n = $urandom_range(1, 4);
            repeat (n) add_char(plain_char());
        end
        else if (roll < 96)
        begin
            add_char(CH_QUOTE);
            n = $urandom_range(0, 4);
            repeat (n)
            begin
                c = any_char();
                if (c == CH_QUOTE)
                    add_char(CH_QUOTE);          // doubled quote
                add_char(c);
            end
            add_char(CH_QUOTE);
        end
        else if (roll < 98)
        begin
            add_char(plain_char());              // quote in unquoted field
            add_char(CH_QUOTE);
        end
        else
        begin
            add_char(CH_QUOTE);                  // stray char after close
            add_char(plain_char());
            add_char(CH_QUOTE);
            add_char(plain_char());
        end
    endfunction

    // Mostly well-formed stream; some records with one field too many or few
    function automatic void add_stream(int unsigned nf, int unsigned nrec);
        int unsigned fields_here;
        int unsigned roll;
        for (int unsigned r = 0; r < nrec; r++)
        begin
            fields_here = nf;
            if ($urandom_range(0, 99) < 12)
                fields_here = $urandom_range(0, 1) ? nf + 1 : (nf > 1 ? nf - 1 : 1);
            for (int unsigned f = 0; f < fields_here; f++)
            begin
                if (f > 0)
                    add_char(CH_COMMA);
                add_field();
            end
            roll = $urandom_range(0, 99);
            if (r + 1 < nrec || roll >= 25)
                add_line_end();
            else if (roll >= 20)
            begin
                add_char(CH_QUOTE);              // left open at end of input
                add_char(plain_char());
            end
        end
        add_eoi();
    endfunction

    function automatic void add_noise();
        int unsigned n;
        n = $urandom_range(1, 20);
        repeat (n) add_char(any_char());
        add_eoi();
    endfunction

    // ------------------------------------------------------------------
    // Idling profile: three phases by progress through the run
    // ------------------------------------------------------------------
    function automatic int unsigned run_phase();
        return (total_words == 0) ? 0 : (accepted_words * 3) / total_words;
    endfunction

    function automatic int unsigned send_idle_pct();
        case (run_phase())
            0:       return 12;
            1:       return 54;
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned recv_idle_pct();
        case (run_phase())
            0:       return 54;
            1:       return 12;
            default: return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: predicts each accepted word, then offers the next one
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        char_word_t w;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                parse_char(s_axis_tdata, s_axis_tuser);
                accepted_words++;
            end
            // a word not yet taken stays on the bus unchanged
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (char_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct())
                begin
                    w = char_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= w.ch;
                    s_axis_tuser  <= w.eoi;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls plus one long hold-off to back up the input
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!hold_done && accepted_words >= total_words / 6)
        begin
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct());
    end

    // ------------------------------------------------------------------
    // Monitor: each event word against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        parse_event_t ev;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_events.size() == 0)
            begin
                $error("unexpected event word: kind %0d tdata %h", m_axis_tuser, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                ev = expected_events.pop_front();
                if (m_axis_tuser !== ev.kind)
                begin
                    $error("kind: expected %0d, got %0d", ev.kind, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[7:0] !== ev.data)
                begin
                    $error("data_byte: expected %h, got %h", ev.data, m_axis_tdata[7:0]);
                    fail_count++;
                end
                if (m_axis_tdata[13:8] !== ev.idx)
                begin
                    $error("field_index: expected %0d, got %0d", ev.idx, m_axis_tdata[13:8]);
                    fail_count++;
                end
                if (m_axis_tdata[16:14] !== ev.err)
                begin
                    $error("error_code: expected %0d, got %0d", ev.err, m_axis_tdata[16:14]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[csv_record_parser] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: fill the word queue, reset, wait for the last event
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        generated_words = 0;
        total_words     = 0;
        accepted_words  = 0;
        fail_count      = 0;
        cycle_count     = 0;
        parser_clear();

        // directed: quoting, doubled quote, CR LF pair, empty line mismatch
        add_char(8'hFF);
        add_char(CH_COMMA);
        add_char(CH_QUOTE);
        add_char(CH_QUOTE);
        add_char(CH_QUOTE);
        add_char(CH_COMMA);
        add_char(CH_QUOTE);
        add_char(CH_CR);
        add_char(CH_LF);
        add_char(CH_LF);                         // empty line: count mismatch
        add_char(8'h78);                         // dropped while stopped
        add_eoi();
        // end of input inside an unquoted record closes it
        add_char(8'h00);
        add_eoi();
        // end of input inside an open quote
        add_char(CH_QUOTE);
        add_char(8'h71);
        add_eoi();
        // quote inside an unquoted field
        add_char(8'h61);
        add_char(CH_QUOTE);
        add_eoi();
        // stray character after a closing quote
        add_char(CH_QUOTE);
        add_char(CH_QUOTE);
        add_char(8'h7A);
        add_eoi();
        // end of input between records
        add_eoi();

        // one header too wide, one exactly at the field limit
        add_stream(MAX_FIELDS + 1, 1);
        add_stream(MAX_FIELDS, 2);
        while (generated_words < RANDOM_WORDS + 25)
        begin
            if ($urandom_range(0, 99) < 15)
                add_noise();
            else if ($urandom_range(0, 99) < 3)
                add_stream($urandom_range(MAX_FIELDS - 4, MAX_FIELDS + 2), 2);
            else
                add_stream($urandom_range(1, 5), $urandom_range(1, 4));
        end
        total_words = char_queue.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (char_queue.size() != 0 || s_axis_tvalid || expected_events.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("[csv_record_parser] OK");
        else
            $display("[csv_record_parser] ERROR");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/csvp_pkg.sv
rtl/core/csv_record_parser.sv
rtl/core/csvp_checker.sv
bench/tb_csv_record_parser.sv
